// ===== hdl/keyed_countdown_timer_table_top_macros.svh =====
// ============================================================================
// Assertion macros for the keyed countdown timer table
// Shared concurrent assertion forms, sampled on the rising clock edge and
// disabled while the active-low reset is asserted.
// ============================================================================
`ifndef KEYED_COUNTDOWN_TIMER_TABLE_TOP_MACROS_SVH
`define KEYED_COUNTDOWN_TIMER_TABLE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KCT_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define KCT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/kct_pkg.sv =====
// ============================================================================
// Keyed countdown timer table package
// Sizes, codes and record types shared by the timer table and its testbench.
// ============================================================================
package kct_pkg;

    // Table sizing.
    localparam int ENTRIES       = 16;
    localparam int KEY_BITS      = 16;
    localparam int TIME_BITS     = 32;
    localparam int IDX_BITS      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_BITS      = $clog2(ENTRIES + 1);

    // Fixed port widths of the transfer fields.
    localparam int KIND_PORT_BITS = 2;
    localparam int KEY_PORT_BITS  = 16;
    localparam int TIME_PORT_BITS = 32;
    localparam int STAT_PORT_BITS = 2;

    // Input item kinds.
    localparam logic [KIND_PORT_BITS-1:0] KIND_POLL  = 2'd0;
    localparam logic [KIND_PORT_BITS-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_PORT_BITS-1:0] KIND_RESET = 2'd2;

    // Result kinds.
    localparam logic RK_EXPIRY = 1'b0;
    localparam logic RK_STATUS = 1'b1;

    // Status codes. Expiry reports carry the inserted code, which is zero.
    localparam logic [STAT_PORT_BITS-1:0] ST_INSERTED = 2'd0;
    localparam logic [STAT_PORT_BITS-1:0] ST_REPLACED = 2'd1;
    localparam logic [STAT_PORT_BITS-1:0] ST_IGNORED  = 2'd2;
    localparam logic [STAT_PORT_BITS-1:0] ST_DROPPED  = 2'd3;

    // One timer entry as held in the table RAM.
    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic                 is_reset;
        logic [TIME_BITS-1:0] remaining;
        logic                 expired;
    } t_entry;

    localparam int ENTRY_BITS = $bits(t_entry);

    // One result item, without its strobe and last flag.
    typedef struct packed {
        logic                      result_kind;
        logic [KEY_PORT_BITS-1:0]  key;
        logic                      is_reset;
        logic [STAT_PORT_BITS-1:0] status;
    } t_result;

endpackage

// ===== hdl/kct_ram.sv =====
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ============================================================================
module kct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [ABITS-1:0] i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [ABITS-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/keyed_countdown_timer_table_top.sv =====
// ============================================================================
// Keyed countdown timer table
// A table of keyed countdown timers held in one RAM and scanned per item.
// ============================================================================
// Usage:
// An item is transferred on a rising edge where i_start is high and o_busy
// is low. A set or reset item with a nonzero duration and a counting poll
// each scan the whole table, one slot per cycle through the table RAM, so
// such an item keeps o_busy high through its scan and the closing done state.
// The single RAM read port sets the rate of one slot per cycle.
// A set or reset with zero duration answers on the next cycle and keeps the
// block idle; a poll that does not count and the unused kind leave no trace.
// Each result appears on the o_ result ports for one cycle with o_valid high.
// A set or reset gives one status result at the end of its scan. A poll gives
// one expiry report per newly expired slot, in slot order, spread over the
// scan; o_last marks the final result of an item. The receiver cannot stall.
// Reset clears all slot valid flags and the last poll time at once; the RAM
// contents need no clearing, since only slots flagged valid are ever used.
// ============================================================================
module keyed_countdown_timer_table_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [kct_pkg::KIND_PORT_BITS-1:0]  i_kind,
    input  logic [kct_pkg::KEY_PORT_BITS-1:0]   i_key,
    input  logic [kct_pkg::TIME_PORT_BITS-1:0]  i_duration,
    input  logic [kct_pkg::TIME_PORT_BITS-1:0]  i_poll_time,
    input  logic [kct_pkg::TIME_PORT_BITS-1:0]  i_period,
    output logic                                o_valid,
    output logic                                o_result_kind,
    output logic [kct_pkg::KEY_PORT_BITS-1:0]   o_key_out,
    output logic                                o_out_is_reset,
    output logic [kct_pkg::STAT_PORT_BITS-1:0]  o_status,
    output logic                                o_last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    localparam int CMP_BITS = kct_pkg::TIME_BITS + 2;

    // Control state.
    t_state                            r_state,     n_state;
    logic                              r_is_poll,   n_is_poll;
    logic [kct_pkg::CNT_BITS-1:0]      r_rd_cnt,    n_rd_cnt;
    logic                              r_chk_vld,   n_chk_vld;
    logic [kct_pkg::IDX_BITS-1:0]      r_chk_idx,   n_chk_idx;
    logic [kct_pkg::ENTRIES-1:0]       r_valid,     n_valid;
    logic                              r_match,     n_match;
    logic [kct_pkg::IDX_BITS-1:0]      r_match_idx, n_match_idx;
    logic                              r_free,      n_free;
    logic [kct_pkg::IDX_BITS-1:0]      r_free_idx,  n_free_idx;
    logic                              r_pend,      n_pend;
    logic [kct_pkg::TIME_BITS-1:0]     r_last_poll, n_last_poll;
    logic                              r_out_vld,   n_out_vld;

    // Item and result payload.
    logic                              r_rst,       n_rst;
    logic [kct_pkg::KEY_BITS-1:0]      r_key,       n_key;
    logic [kct_pkg::TIME_BITS-1:0]     r_dur,       n_dur;
    logic [kct_pkg::TIME_BITS-1:0]     r_dec,       n_dec;
    kct_pkg::t_result                  r_pend_res,  n_pend_res;
    kct_pkg::t_result                  r_out,       n_out;
    logic                              r_out_last,  n_out_last;

    // RAM ports.
    logic                              ram_we;
    logic [kct_pkg::IDX_BITS-1:0]      ram_waddr;
    kct_pkg::t_entry                   ram_wdata;
    logic [kct_pkg::IDX_BITS-1:0]      ram_raddr;
    logic [kct_pkg::ENTRY_BITS-1:0]    ram_rdata;
    kct_pkg::t_entry                   rd_entry;

    // Item decode and per-slot arithmetic.
    logic                              accept;
    logic [kct_pkg::TIME_BITS-1:0]     in_now;
    logic [kct_pkg::TIME_BITS-1:0]     in_per;
    logic [kct_pkg::TIME_BITS-1:0]     in_dur;
    logic [CMP_BITS-1:0]               cmp_lhs;
    logic [CMP_BITS-1:0]               cmp_rhs;
    logic                              poll_counts;
    logic                              slot_live;
    logic [kct_pkg::TIME_BITS-1:0]     new_rem;
    logic                              slot_fire;

    assign accept    = i_start && (r_state == S_IDLE);
    assign in_now    = kct_pkg::TIME_BITS'(i_poll_time);
    assign in_per    = kct_pkg::TIME_BITS'(i_period);
    assign in_dur    = kct_pkg::TIME_BITS'(i_duration);
    assign ram_raddr = r_rd_cnt[kct_pkg::IDX_BITS-1:0];
    assign rd_entry  = kct_pkg::t_entry'(ram_rdata);

    // A poll counts when 2*now exceeds period + 2*last poll time.
    assign cmp_lhs     = {1'b0, in_now, 1'b0};
    assign cmp_rhs     = {2'b00, in_per} + {1'b0, r_last_poll, 1'b0};
    assign poll_counts = (cmp_lhs > cmp_rhs);

    // Saturating countdown of the slot that the RAM returned this cycle.
    assign slot_live = r_valid[r_chk_idx] && !rd_entry.expired;
    assign new_rem   = (rd_entry.remaining > r_dec) ? (rd_entry.remaining - r_dec)
                                                    : '0;
    assign slot_fire = slot_live && (new_rem == '0);

    // Table RAM. Each scan reads a slot in the cycle before it may write it back,
    // and the final write lands before the next item can start a read, so no
    // read whose data is used ever meets a write to the same slot.
    kct_ram #(
        .WIDTH (kct_pkg::ENTRY_BITS),
        .DEPTH (kct_pkg::ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer, scan bookkeeping and result selection.
    always_comb begin
        n_state     = r_state;
        n_is_poll   = r_is_poll;
        n_rd_cnt    = r_rd_cnt;
        n_chk_vld   = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_valid     = r_valid;
        n_match     = r_match;
        n_match_idx = r_match_idx;
        n_free      = r_free;
        n_free_idx  = r_free_idx;
        n_pend      = r_pend;
        n_pend_res  = r_pend_res;
        n_last_poll = r_last_poll;
        n_rst       = r_rst;
        n_key       = r_key;
        n_dur       = r_dur;
        n_dec       = r_dec;
        n_out_vld   = 1'b0;
        n_out       = r_out;
        n_out_last  = r_out_last;
        ram_we      = 1'b0;
        ram_waddr   = r_chk_idx;
        ram_wdata   = '{key: rd_entry.key, is_reset: rd_entry.is_reset,
                        remaining: new_rem, expired: slot_fire};

        case (r_state)
            S_IDLE: begin
                n_rd_cnt = '0;
                n_match  = 1'b0;
                n_free   = 1'b0;
                n_pend   = 1'b0;
                if (accept) begin
                    n_key = kct_pkg::KEY_BITS'(i_key);
                    n_rst = (i_kind == kct_pkg::KIND_RESET);
                    n_dur = in_dur;
                    n_dec = (in_per != '0) ? in_per : kct_pkg::TIME_BITS'(1);
                    if (i_kind == kct_pkg::KIND_POLL) begin
                        if (poll_counts) begin
                            n_is_poll   = 1'b1;
                            n_last_poll = in_now;
                            n_state     = S_SCAN;
                        end
                    end else if (i_kind == kct_pkg::KIND_SET ||
                                 i_kind == kct_pkg::KIND_RESET) begin
                        if (in_dur == '0) begin
                            // Zero duration answers at once and leaves the table.
                            n_out_vld  = 1'b1;
                            n_out_last = 1'b1;
                            n_out      = '{result_kind: kct_pkg::RK_STATUS,
                                           key: i_key,
                                           is_reset: (i_kind == kct_pkg::KIND_RESET),
                                           status: kct_pkg::ST_IGNORED};
                        end else begin
                            n_is_poll = 1'b0;
                            n_state   = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // Issue the next read, or finish once every slot is read.
                if (r_rd_cnt != kct_pkg::CNT_BITS'(kct_pkg::ENTRIES)) begin
                    n_chk_vld = 1'b1;
                    n_chk_idx = r_rd_cnt[kct_pkg::IDX_BITS-1:0];
                    n_rd_cnt  = r_rd_cnt + kct_pkg::CNT_BITS'(1);
                end else begin
                    n_state = S_DONE;
                end

                // Work on the slot whose data arrived this cycle.
                if (r_chk_vld) begin
                    if (r_is_poll) begin
                        ram_we = slot_live;
                        if (slot_fire) begin
                            // Release the held report; it is not the last one.
                            if (r_pend) begin
                                n_out_vld  = 1'b1;
                                n_out_last = 1'b0;
                                n_out      = r_pend_res;
                            end
                            n_pend     = 1'b1;
                            n_pend_res = '{result_kind: kct_pkg::RK_EXPIRY,
                                           key: kct_pkg::KEY_PORT_BITS'(rd_entry.key),
                                           is_reset: rd_entry.is_reset,
                                           status: kct_pkg::ST_INSERTED};
                        end
                    end else if (r_valid[r_chk_idx]) begin
                        if (!r_match && rd_entry.key == r_key &&
                            rd_entry.is_reset == r_rst) begin
                            n_match     = 1'b1;
                            n_match_idx = r_chk_idx;
                        end
                    end else if (!r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_chk_idx;
                    end
                end
            end

            S_DONE: begin
                n_state = S_IDLE;
                if (r_is_poll) begin
                    if (r_pend) begin
                        n_out_vld  = 1'b1;
                        n_out_last = 1'b1;
                        n_out      = r_pend_res;
                    end
                end else begin
                    // Start the timer; a reset class timer starts at zero.
                    ram_wdata  = '{key: r_key, is_reset: r_rst,
                                   remaining: r_rst ? '0 : r_dur, expired: 1'b0};
                    n_out_vld  = 1'b1;
                    n_out_last = 1'b1;
                    n_out      = '{result_kind: kct_pkg::RK_STATUS,
                                   key: kct_pkg::KEY_PORT_BITS'(r_key),
                                   is_reset: r_rst,
                                   status: kct_pkg::ST_DROPPED};
                    if (r_match) begin
                        ram_we       = 1'b1;
                        ram_waddr    = r_match_idx;
                        n_out.status = kct_pkg::ST_REPLACED;
                    end else if (r_free) begin
                        ram_we              = 1'b1;
                        ram_waddr           = r_free_idx;
                        n_valid[r_free_idx] = 1'b1;
                        n_out.status        = kct_pkg::ST_INSERTED;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_is_poll   <= 1'b0;
            r_rd_cnt    <= '0;
            r_chk_vld   <= 1'b0;
            r_chk_idx   <= '0;
            r_valid     <= '0;
            r_match     <= 1'b0;
            r_match_idx <= '0;
            r_free      <= 1'b0;
            r_free_idx  <= '0;
            r_pend      <= 1'b0;
            r_last_poll <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_is_poll   <= n_is_poll;
            r_rd_cnt    <= n_rd_cnt;
            r_chk_vld   <= n_chk_vld;
            r_chk_idx   <= n_chk_idx;
            r_valid     <= n_valid;
            r_match     <= n_match;
            r_match_idx <= n_match_idx;
            r_free      <= n_free;
            r_free_idx  <= n_free_idx;
            r_pend      <= n_pend;
            r_last_poll <= n_last_poll;
            r_out_vld   <= n_out_vld;
        end
        r_rst      <= n_rst;
        r_key      <= n_key;
        r_dur      <= n_dur;
        r_dec      <= n_dec;
        r_pend_res <= n_pend_res;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_out_vld;
    assign o_result_kind  = r_out.result_kind;
    assign o_key_out      = r_out.key;
    assign o_out_is_reset = r_out.is_reset;
    assign o_status       = r_out.status;
    assign o_last         = r_out_last;

    // Assertions.
`include "keyed_countdown_timer_table_top_macros.svh"

    `KCT_ASSERT_NEXT(a_done_returns_idle, i_clk, i_rst_n, r_state == S_DONE, r_state == S_IDLE, "scan end did not return to idle")

    `KCT_ASSERT_NEXT(a_scan_ends_in_done, i_clk, i_rst_n, r_state == S_SCAN && r_rd_cnt == kct_pkg::CNT_BITS'(kct_pkg::ENTRIES), r_state == S_DONE && !r_chk_vld, "scan did not finish after the last slot")

    `KCT_ASSERT_SAME(a_status_is_last, i_clk, i_rst_n, o_valid && o_result_kind == kct_pkg::RK_STATUS, o_last && !o_busy, "status result not last or not at scan end")

    `KCT_ASSERT_SAME(a_scan_write_slot, i_clk, i_rst_n, ram_we && r_state == S_SCAN, r_chk_vld && r_is_poll && ram_waddr == r_chk_idx, "write during scan away from the checked slot")

endmodule

// ===== verif/tb.sv =====
// ============================================================================
// Testbench for the keyed countdown timer table
// Drives poll, set and reset commands through the start/busy handshake and
// checks every result strobe against a cycle-free model of the timer table:
// directed corner cases first, then random traffic over several sender idle
// phases, then a closing burst that fills the table and expires everything.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kct_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 74;
    localparam int PHASE_ITEMS  = 28;
    localparam int DRAIN_CYCLES = 4 * (ENTRIES + 2);
    localparam int CYCLE_LIMIT  = 200_000;
    localparam int POOL_KEYS    = 10;

    // The fourth kind code has no meaning and must be ignored.
    localparam logic [KIND_PORT_BITS-1:0] KIND_UNUSED = 2'd3;

    // One command as it is presented on the input ports.
    typedef struct packed {
        logic [KIND_PORT_BITS-1:0] kind;
        logic [KEY_PORT_BITS-1:0]  key;
        logic [TIME_PORT_BITS-1:0] duration;
        logic [TIME_PORT_BITS-1:0] poll_time;
        logic [TIME_PORT_BITS-1:0] period;
    } timer_cmd_t;

    // One result together with its last flag.
    typedef struct packed {
        t_result res;
        logic    last;
    } timer_result_t;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_start = 1'b0;
    logic                      o_busy;
    logic [KIND_PORT_BITS-1:0] i_kind = '0;
    logic [KEY_PORT_BITS-1:0]  i_key = '0;
    logic [TIME_PORT_BITS-1:0] i_duration = '0;
    logic [TIME_PORT_BITS-1:0] i_poll_time = '0;
    logic [TIME_PORT_BITS-1:0] i_period = '0;
    logic                      o_valid;
    logic                      o_result_kind;
    logic [KEY_PORT_BITS-1:0]  o_key_out;
    logic                      o_out_is_reset;
    logic [STAT_PORT_BITS-1:0] o_status;
    logic                      o_last;

    // Commands waiting for transfer and results waiting to arrive.
    timer_cmd_t    timer_cmds[$];
    timer_result_t expected_timer_results[$];

    // Model copy of the timer table.
    logic                 timer_armed    [ENTRIES];
    logic [KEY_BITS-1:0]  timer_key      [ENTRIES];
    logic                 timer_is_reset [ENTRIES];
    logic [TIME_BITS-1:0] timer_left     [ENTRIES];
    logic                 timer_fired    [ENTRIES];
    logic [TIME_BITS-1:0] last_tick_ms;

    int n_errors = 0;
    int n_accepted = 0;
    int n_status_seen = 0;
    int n_expiry_seen = 0;
    int n_ticks_counted = 0;
    int cycle_count = 0;

    keyed_countdown_timer_table_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_kind         (i_kind),
        .i_key          (i_key),
        .i_duration     (i_duration),
        .i_poll_time    (i_poll_time),
        .i_period       (i_period),
        .o_valid        (o_valid),
        .o_result_kind  (o_result_kind),
        .o_key_out      (o_key_out),
        .o_out_is_reset (o_out_is_reset),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        n_errors++;
        $display("[%0t] MISMATCH: %s", $realtime, what);
    endtask

    task automatic queue_cmd(input logic [KIND_PORT_BITS-1:0] kind,
                             input logic [KEY_PORT_BITS-1:0] key,
                             input logic [TIME_PORT_BITS-1:0] duration,
                             input logic [TIME_PORT_BITS-1:0] poll_time,
                             input logic [TIME_PORT_BITS-1:0] period);
        timer_cmd_t cmd;
        cmd.kind      = kind;
        cmd.key       = key;
        cmd.duration  = duration;
        cmd.poll_time = poll_time;
        cmd.period    = period;
        timer_cmds.insert(timer_cmds.size(), cmd);
    endtask

    // Applies one transferred command to the table copy and queues the
    // results it must produce.
    task automatic update_timer_table(input timer_cmd_t cmd);
        logic [TIME_PORT_BITS+1:0] now_x2;
        logic [TIME_PORT_BITS+1:0] threshold;
        logic [TIME_BITS-1:0]      step;
        logic [STAT_PORT_BITS-1:0] st;
        logic                      rst_class;
        int                        hit;
        int                        free_slot;
        timer_result_t             r;
        timer_result_t             batch[$];
        case (cmd.kind)
            KIND_POLL: begin
                now_x2    = {1'b0, cmd.poll_time, 1'b0};
                threshold = {2'b00, cmd.period} + {1'b0, last_tick_ms, 1'b0};
                if (now_x2 > threshold) begin
                    n_ticks_counted++;
                    step = (cmd.period != '0) ? cmd.period : 1;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (timer_armed[i] && !timer_fired[i]) begin
                            timer_left[i] = (timer_left[i] > step) ?
                                            timer_left[i] - step : '0;
                        end
                    end
                    // Newly run-down timers are reported once, in slot order.
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (timer_armed[i] && !timer_fired[i] && timer_left[i] == '0) begin
                            timer_fired[i]    = 1'b1;
                            r.res.result_kind = RK_EXPIRY;
                            r.res.key         = timer_key[i];
                            r.res.is_reset    = timer_is_reset[i];
                            r.res.status      = ST_INSERTED;
                            r.last            = 1'b0;
                            batch.insert(batch.size(), r);
                        end
                    end
                    for (int j = 0; j < batch.size(); j++) begin
                        r      = batch[j];
                        r.last = (j == batch.size() - 1);
                        expected_timer_results.insert(expected_timer_results.size(), r);
                    end
                    last_tick_ms = cmd.poll_time;
                end
            end
            KIND_SET, KIND_RESET: begin
                rst_class = (cmd.kind == KIND_RESET);
                hit       = -1;
                free_slot = -1;
                if (cmd.duration == '0) begin
                    st = ST_IGNORED;
                end else begin
                    // A live entry of the same key and class wins over any free slot.
                    for (int i = 0; i < ENTRIES && hit < 0; i++) begin
                        if (timer_armed[i]) begin
                            if (timer_key[i] == cmd.key && timer_is_reset[i] == rst_class)
                                hit = i;
                        end else if (free_slot < 0) begin
                            free_slot = i;
                        end
                    end
                    if (hit >= 0) begin
                        st = ST_REPLACED;
                    end else if (free_slot >= 0) begin
                        hit                 = free_slot;
                        st                  = ST_INSERTED;
                        timer_armed[hit]    = 1'b1;
                        timer_key[hit]      = cmd.key;
                        timer_is_reset[hit] = rst_class;
                    end else begin
                        st = ST_DROPPED;
                    end
                    if (hit >= 0) begin
                        timer_left[hit]  = rst_class ? '0 : cmd.duration;
                        timer_fired[hit] = 1'b0;
                    end
                end
                r.res.result_kind = RK_STATUS;
                r.res.key         = cmd.key;
                r.res.is_reset    = rst_class;
                r.res.status      = st;
                r.last            = 1'b1;
                expected_timer_results.insert(expected_timer_results.size(), r);
            end
            default: begin
                // The unused kind leaves no trace.
            end
        endcase
    endtask

    // Driver: presents the head command and holds it until it is transferred.
    always @(posedge i_clk) begin : driver
        int   idle_pct;
        logic go;
        case ((n_accepted / PHASE_ITEMS) % 4)
            1:       idle_pct = 62;
            3:       idle_pct = 29;
            default: idle_pct = 0;
        endcase
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && o_busy) begin
            // The pending command stays on the ports.
        end else begin
            if (i_start) begin
                update_timer_table(timer_cmds[0]);
                void'(timer_cmds.pop_front());
                n_accepted++;
            end
            go = (timer_cmds.size() != 0) && ($urandom_range(99) >= idle_pct);
            if (go) begin
                i_kind      <= timer_cmds[0].kind;
                i_key       <= timer_cmds[0].key;
                i_duration  <= timer_cmds[0].duration;
                i_poll_time <= timer_cmds[0].poll_time;
                i_period    <= timer_cmds[0].period;
            end
            i_start <= go;
        end
    end

    // Monitor: every strobed result must match the oldest expectation.
    always @(posedge i_clk) begin : monitor
        timer_result_t exp_r;
        if (i_rst_n && o_valid) begin
            if (expected_timer_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result kind %0d key %h",
                                        o_result_kind, o_key_out));
            end else begin
                exp_r = expected_timer_results.pop_front();
                if (o_result_kind !== exp_r.res.result_kind)
                    flag_mismatch($sformatf("result_kind %b, expected %b",
                                            o_result_kind, exp_r.res.result_kind));
                if (o_key_out !== exp_r.res.key)
                    flag_mismatch($sformatf("key_out %h, expected %h",
                                            o_key_out, exp_r.res.key));
                if (o_out_is_reset !== exp_r.res.is_reset)
                    flag_mismatch($sformatf("out_is_reset %b, expected %b (key %h)",
                                            o_out_is_reset, exp_r.res.is_reset,
                                            exp_r.res.key));
                if (o_status !== exp_r.res.status)
                    flag_mismatch($sformatf("status %0d, expected %0d (key %h)",
                                            o_status, exp_r.res.status, exp_r.res.key));
                if (o_last !== exp_r.last)
                    flag_mismatch($sformatf("last %b, expected %b (key %h)",
                                            o_last, exp_r.last, exp_r.res.key));
                if (exp_r.res.result_kind == RK_STATUS)
                    n_status_seen++;
                else
                    n_expiry_seen++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("keyed_countdown_timer_table_top test failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [KEY_PORT_BITS-1:0]  key_pool [POOL_KEYS];
        logic [KEY_PORT_BITS-1:0]  key;
        logic [KIND_PORT_BITS-1:0] kind;
        logic [TIME_PORT_BITS-1:0] dur;
        logic [TIME_PORT_BITS-1:0] now;
        logic [TIME_PORT_BITS-1:0] per;
        int                        gen_ms;
        int                        step;
        int                        pick;
        int                        sel;

        // Table copy after reset.
        for (int i = 0; i < ENTRIES; i++) begin
            timer_armed[i]    = 1'b0;
            timer_key[i]      = '0;
            timer_is_reset[i] = 1'b0;
            timer_left[i]     = '0;
            timer_fired[i]    = 1'b0;
        end
        last_tick_ms = '0;

        // Directed: non-counting poll, unused kind, zero durations.
        queue_cmd(KIND_POLL, 16'hFFFF, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_cmd(KIND_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(KIND_SET, 16'hFFFF, 32'd0, $urandom, $urandom);
        queue_cmd(KIND_RESET, 16'h0000, 32'd0, $urandom, $urandom);
        // Insert, replace, and a reset-class twin that starts at zero.
        queue_cmd(KIND_SET, 16'h0001, 32'hFFFF_FFFF, $urandom, $urandom);
        queue_cmd(KIND_SET, 16'h0001, 32'd3, $urandom, $urandom);
        queue_cmd(KIND_RESET, 16'h0001, 32'd5, $urandom, $urandom);
        // Zero period counts by one; an equal-threshold poll does not count.
        queue_cmd(KIND_POLL, $urandom, $urandom, 32'd1, 32'd0);
        queue_cmd(KIND_POLL, $urandom, $urandom, 32'd1, 32'd0);
        queue_cmd(KIND_POLL, $urandom, $urandom, 32'd3, 32'd2);
        // Counting poll with nothing newly expired.
        queue_cmd(KIND_POLL, $urandom, $urandom, 32'd4, 32'd0);
        // Re-arm expired entries, add one more, then expire two in one poll.
        queue_cmd(KIND_SET, 16'h0001, 32'd2, $urandom, $urandom);
        queue_cmd(KIND_RESET, 16'h0001, 32'd9, $urandom, $urandom);
        queue_cmd(KIND_SET, 16'h0002, 32'd1, $urandom, $urandom);
        queue_cmd(KIND_POLL, $urandom, $urandom, 32'd5, 32'd0);

        // Random traffic: a small key pool so entries get replaced and the
        // table fills, with mostly increasing poll times.
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        for (int i = 2; i < POOL_KEYS; i++)
            key_pool[i] = $urandom;
        gen_ms = 5;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                sel = $urandom_range(99);
                if (sel < 85)
                    step = $urandom_range(0, 40);
                else
                    step = $urandom_range(1000, 100000);
                if ($urandom_range(99) < 8 && gen_ms > 50) begin
                    // A stale time stamp, earlier than the latest generated poll time.
                    now = gen_ms - $urandom_range(1, 50);
                end else begin
                    gen_ms = gen_ms + step;
                    now    = gen_ms;
                end
                sel = $urandom_range(99);
                if (sel < 65)
                    per = $urandom_range(0, 2 * step + 1);
                else if (sel < 85)
                    per = '0;
                else
                    per = $urandom;
                queue_cmd(KIND_POLL, $urandom, $urandom, now, per);
            end else if (pick < 95) begin
                kind = (pick < 75) ? KIND_SET : KIND_RESET;
                key  = ($urandom_range(99) < 10) ? 16'($urandom) :
                       key_pool[$urandom_range(0, POOL_KEYS - 1)];
                sel  = $urandom_range(99);
                if (sel < 8)
                    dur = '0;
                else if (sel < 78)
                    dur = $urandom_range(1, 60);
                else if (sel < 90)
                    dur = $urandom_range(61, 200000);
                else
                    dur = $urandom;
                queue_cmd(kind, key, dur, $urandom, $urandom);
            end else begin
                queue_cmd(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom);
            end
        end

        // Closing burst: more fresh timers than slots, so the table is full
        // and later sets and resets are dropped.
        for (int j = 0; j < ENTRIES + 1; j++)
            queue_cmd((j % 2) ? KIND_RESET : KIND_SET, $urandom,
                      $urandom_range(1, 60), $urandom, $urandom);
        queue_cmd(KIND_RESET, $urandom, 32'hFFFF_FFFF, $urandom, $urandom);
        // Maximum time and period: every running timer runs down at once.
        queue_cmd(KIND_POLL, $urandom, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_cmd(KIND_POLL, $urandom, $urandom, 32'hFFFF_FFFF, 32'd0);
        queue_cmd(KIND_SET, key_pool[0], 32'hFFFF_FFFF, $urandom, $urandom);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (timer_cmds.size() != 0 || i_start)
            @(posedge i_clk);
        while (expected_timer_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Transferred %0d commands; %0d polls counted down the table.",
                 n_accepted, n_ticks_counted);
        $display("Checked %0d status results and %0d expiry reports; %0d mismatches.",
                 n_status_seen, n_expiry_seen, n_errors);
        if (n_errors == 0) begin
            $display("keyed_countdown_timer_table_top test passed");
        end else begin
            $display("keyed_countdown_timer_table_top test failed");
        end
        $finish;
    end
endmodule

// ===== keyed_countdown_timer_table_top.f =====
+incdir+hdl
hdl/kct_pkg.sv
hdl/kct_ram.sv
hdl/keyed_countdown_timer_table_top.sv
verif/tb.sv
